/* hdl/modular_add_multiply_macros.svh */
// ----------------------------------------------------------------------------
// Modular add / multiply assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MODULAR_ADD_MULTIPLY_MACROS_SVH
`define MODULAR_ADD_MULTIPLY_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MAM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("modular_add_multiply: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MAM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("modular_add_multiply: next-cycle check failed");

`endif

/* hdl/mam_pkg.sv */
// ----------------------------------------------------------------------------
// Modular add / multiply package
// Command codes, default width and the control word that runs down the chain.
// ----------------------------------------------------------------------------
package mam_pkg;

   localparam int DEFAULT_WIDTH = 64;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_MUL = 1'b1;

   // Control that travels with each word from cell to cell.
   typedef struct packed {
      logic valid;
      logic cmd;
   } mam_ctl_type;

endpackage

/* hdl/mam_cell.sv */
// ----------------------------------------------------------------------------
// Modular add / multiply cell
// One bit of the double-and-add scan: a doubling stage (multiply only), then a conditional add.
// ----------------------------------------------------------------------------
module mam_cell #(
   parameter int WIDTH = mam_pkg::DEFAULT_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic [WIDTH-1:0]     modulus,
   input  mam_pkg::mam_ctl_type ctl_i,
   input  logic [WIDTH-1:0]     acc_i,
   input  logic [WIDTH-1:0]     mult_i,
   input  logic [WIDTH-1:0]     oper_i,
   output mam_pkg::mam_ctl_type ctl_o,
   output logic [WIDTH-1:0]     acc_o,
   output logic [WIDTH-1:0]     mult_o,
   output logic [WIDTH-1:0]     oper_o
);
   import mam_pkg::*;

   // Compare-and-subtract add; every sum and difference wraps at WIDTH bits.
   function automatic logic [WIDTH-1:0] mod_add(input logic [WIDTH-1:0] x,
                                                input logic [WIDTH-1:0] y,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] lim;
      lim = WIDTH'(m - y);
      if (x < lim) begin
         return WIDTH'(x + y);
      end
      return WIDTH'(x + y - m);
   endfunction

   mam_ctl_type      dbl_ctl_ff, dbl_ctl_in, add_ctl_ff, add_ctl_in;
   logic [WIDTH-1:0] dbl_acc_ff, dbl_acc_in, add_acc_ff, add_acc_in;
   logic [WIDTH-1:0] dbl_mult_ff, dbl_mult_in, add_mult_ff, add_mult_in;
   logic [WIDTH-1:0] dbl_oper_ff, dbl_oper_in, add_oper_ff, add_oper_in;

   always_comb begin
      dbl_ctl_in  = ctl_i;
      dbl_mult_in = mult_i;
      dbl_oper_in = oper_i;
      dbl_acc_in  = (ctl_i.cmd == CMD_MUL) ? mod_add(acc_i, acc_i, modulus) : acc_i;

      add_ctl_in  = dbl_ctl_ff;
      add_oper_in = dbl_oper_ff;
      add_mult_in = {dbl_mult_ff[WIDTH-2:0], 1'b0};
      add_acc_in  = dbl_mult_ff[WIDTH-1] ? mod_add(dbl_acc_ff, dbl_oper_ff, modulus)
                                         : dbl_acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbl_ctl_ff <= '0;
         add_ctl_ff <= '0;
      end else if (enable) begin
         dbl_ctl_ff <= dbl_ctl_in;
         add_ctl_ff <= add_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dbl_acc_ff  <= dbl_acc_in;
         dbl_mult_ff <= dbl_mult_in;
         dbl_oper_ff <= dbl_oper_in;
         add_acc_ff  <= add_acc_in;
         add_mult_ff <= add_mult_in;
         add_oper_ff <= add_oper_in;
      end
   end

   assign ctl_o  = add_ctl_ff;
   assign acc_o  = add_acc_ff;
   assign mult_o = add_mult_ff;
   assign oper_o = add_oper_ff;

endmodule

/* hdl/modular_add_multiply.sv */
// ----------------------------------------------------------------------------
// Modular add / multiply unit
// Modular sum or interleaved double-and-add product over a chain of bit cells.
// ----------------------------------------------------------------------------
// Usage: each word on the req_ stream carries a command in req_tuser and two
// operands in req_tdata; each gives exactly one word on the rsp_ stream, in
// order. Command add returns the compare-and-subtract modular sum; command
// multiply returns the left-to-right double-and-add product over every bit
// of operand_a. All sums and differences wrap at WIDTH bits.
// Path: a word accepted at a clock edge is loaded into the first of the
// 2*WIDTH register stages at that edge and moves on stage by stage to the
// last, whose register drives rsp_tdata. Throughput is one word per cycle
// while the receiver takes results.
// Stalls: the whole chain advances together. When a result waits on
// rsp_tvalid without rsp_tready, the chain holds and req_tready drops; empty
// slots in the chain still move forward whenever the output slot is free.
// Reset clears every valid flag in the chain and loads the modulus with all
// ones. The modulus is written on the csr_ channel, always ready; the user
// must write it only while no word is in flight, the block does not enforce it.
// ----------------------------------------------------------------------------
module modular_add_multiply #(
   parameter int WIDTH = mam_pkg::DEFAULT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request: tdata = operand_a, operand_b (low bits up), zero padded to bytes.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((2*WIDTH+7)/8)*8-1:0]        req_tdata,
   // Request tuser = command.
   input  logic                                req_tuser,
   // Response: tdata = result, zero padded to bytes.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // Modulus write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [WIDTH-1:0]                    csr_data
);
   import mam_pkg::*;

   localparam int RSP_W = ((WIDTH + 7) / 8) * 8;

   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic             enable;
   logic [WIDTH-1:0] oper_a, oper_b;

   // Taps between neighboring cells; entry zero is fed from the request port.
   mam_ctl_type      ctl_chain  [0:WIDTH];
   logic [WIDTH-1:0] acc_chain  [0:WIDTH];
   logic [WIDTH-1:0] mult_chain [0:WIDTH];
   logic [WIDTH-1:0] oper_chain [0:WIDTH];

   // The chain moves whenever the output slot is empty or being taken.
   assign enable     = rsp_tready || !rsp_tvalid;
   assign req_tready = enable;
   assign csr_ready  = 1'b1;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_valid && csr_ready) begin
         modulus_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '1;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   assign oper_a = req_tdata[WIDTH-1:0];
   assign oper_b = req_tdata[2*WIDTH-1:WIDTH];

   // A multiply starts from zero and scans operand_a. An add starts from
   // operand_a with only the top multiplier bit set, so the first cell adds
   // operand_b once without doubling and every later cell passes it through.
   always_comb begin
      ctl_chain[0].valid = req_tvalid;
      ctl_chain[0].cmd   = req_tuser;
      oper_chain[0]      = oper_b;
      if (req_tuser == CMD_MUL) begin
         acc_chain[0]  = '0;
         mult_chain[0] = oper_a;
      end else begin
         acc_chain[0]  = oper_a;
         mult_chain[0] = {1'b1, {(WIDTH-1){1'b0}}};
      end
   end

   for (genvar k = 0; k < WIDTH; k++) begin : g_cell
      mam_cell #(
         .WIDTH (WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .modulus (modulus_ff),
         .ctl_i   (ctl_chain[k]),
         .acc_i   (acc_chain[k]),
         .mult_i  (mult_chain[k]),
         .oper_i  (oper_chain[k]),
         .ctl_o   (ctl_chain[k+1]),
         .acc_o   (acc_chain[k+1]),
         .mult_o  (mult_chain[k+1]),
         .oper_o  (oper_chain[k+1])
      );
   end

   // The last cell's register is the output register.
   assign rsp_tvalid = ctl_chain[WIDTH].valid;
   assign rsp_tdata  = RSP_W'(acc_chain[WIDTH]);

endmodule

/* hdl/mam_checker.sv */
// ----------------------------------------------------------------------------
// Modular add / multiply port checker
// Watches the top-level ports for stall and flow-control behavior.
// ----------------------------------------------------------------------------
`include "modular_add_multiply_macros.svh"

module mam_checker #(
   parameter int RSP_W = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             csr_ready
);

   // A stalled result word stays put.
   `MAM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // A stalled output freezes the whole chain, so no request is taken.
   `MAM_ASSERT_IMPL(a_stall_blocks_req, rsp_tvalid && !rsp_tready, !req_tready)

   // An empty output slot always lets the chain move and take a request.
   `MAM_ASSERT_IMPL(a_empty_takes_req, !rsp_tvalid, req_tready)

   // Nothing comes out of a freshly cleared chain, and the modulus port is open.
   `MAM_ASSERT_IMPL(a_reset_clears, $past(reset), !rsp_tvalid && csr_ready)

endmodule

bind modular_add_multiply mam_checker #(
   .RSP_W (((WIDTH + 7) / 8) * 8)
) u_mam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
